### rtl/assert_macros.svh
// Assertion macros included by the top-level core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property holds at every edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/mf2d_pkg.sv
// Package for the 2D median filter: constants, types, state encoding
package mf2d_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_KERNEL_DEF = 7;
    localparam int PIX_W = 8;
    localparam int CFG_AW = 4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KW     = 2'd2;
    localparam logic [1:0] REG_KH     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_ACC,
        ST_SORT,
        ST_OUT
    } mf2d_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take;      // latch input word, write store, advance input position
        logic check;     // compare position against output target
        logic clr_win;   // start window sweep
        logic rd;        // issue store read for current tap
        logic acc;       // count tap against median
        logic pick;      // binary search step
        logic emit;      // load output register, advance output position
        logic restart;   // clear counters
    } mf2d_cmd_t;

    // Datapath status to controller
    typedef struct packed {
        logic skip;      // drain word inside frame: drop
        logic due;       // an output is due for this word
        logic win_done;  // last tap issued
        logic srch_done; // search finished
    } mf2d_sts_t;
endpackage

### rtl/mf2d_if.sv
// Valid/ready stream interface carrying a payload
interface mf2d_if #(parameter int DW = 9) (input logic clk);
    logic          valid;
    logic          ready;
    logic [DW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/mf2d_ctrl.sv
// Controller state machine for the median filter
module mf2d_ctrl
    import mf2d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_busy,
    input  mf2d_sts_t  sts,
    output mf2d_cmd_t  cmd
);
    mf2d_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (sts.skip || !sts.due) state_next = ST_IDLE;
                else state_next = ST_READ;
            end
            ST_READ:  state_next = ST_ACC;
            ST_ACC:   if (sts.win_done) state_next = ST_SORT; else state_next = ST_READ;
            ST_SORT:  if (sts.srch_done) state_next = ST_OUT; else state_next = ST_READ;
            ST_OUT:   if (!out_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:  begin in_ready = 1'b1; cmd.take = in_valid; end
            ST_CHECK: begin cmd.check = 1'b1; cmd.clr_win = 1'b1; end
            ST_READ:  cmd.rd = 1'b1;
            ST_ACC:   cmd.acc = 1'b1;
            ST_SORT:  cmd.pick = 1'b1;
            ST_OUT:   cmd.emit = !out_busy;
            default:  cmd = '0;
        endcase
    end
endmodule

### rtl/mf2d_dp.sv
// Datapath: line store, counters, window sweep and counting median search
module mf2d_dp
    import mf2d_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = MAX_KERNEL_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [PIX_W-1:0] pixel,
    input  logic             drain,
    input  logic [10:0]      image_width,
    input  logic [15:0]      image_height,
    input  logic [2:0]       kernel_width,
    input  logic [2:0]       kernel_height,
    input  logic             cfg_wr,
    input  mf2d_cmd_t        cmd,
    output mf2d_sts_t        sts,
    output logic [PIX_W-1:0] med,
    output logic             last
);
    localparam int DEPTH = MAX_WIDTH * MAX_KERNEL;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int KW = $clog2(MAX_KERNEL + 1);
    localparam int KLIM = (MAX_KERNEL - 1) | 1;
    localparam int RMAX = KLIM / 2;
    localparam int RW = 17;

    logic [PIX_W-1:0] store [DEPTH];

    // Effective configuration
    logic [CW-1:0] w;
    logic [15:0]   h;
    logic [KW-1:0] kw, kh, rx, ry;
    logic [3:0]    kwo, kho;
    always_comb
    begin
        if (image_width == 11'd0) w = CW'(1);
        else if ({21'd0, image_width} > MAX_WIDTH) w = CW'(MAX_WIDTH);
        else w = CW'(image_width);
        h = (image_height == 16'd0) ? 16'd1 : image_height;
        kwo = {1'b0, kernel_width | 3'd1};
        kho = {1'b0, kernel_height | 3'd1};
        kw = (32'(kwo) > KLIM) ? KW'(KLIM) : KW'(kwo);
        kh = (32'(kho) > KLIM) ? KW'(KLIM) : KW'(kho);
        rx = kw >> 1;
        ry = kh >> 1;
    end

    // Positions: rows are kept wide enough to pass the last row during drain
    logic [RW-1:0] in_row_reg, out_row_reg;
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [AW-1:0] wp_reg;         // input raster index modulo DEPTH
    logic [AW-1:0] obase_reg;      // output pixel raster index modulo DEPTH

    logic last_next;
    assign last_next = (out_row_reg == RW'(h - 16'd1)) && (out_col_reg == w - CW'(1));

    // Input position in frame and target comparison by row/col
    logic in_frame, due;
    logic [RW-1:0] trow;
    logic [CW:0]   tcol;
    always_comb
    begin
        in_frame = in_row_reg < RW'(h);
        tcol = {1'b0, out_col_reg} + (CW+1)'(rx);
        trow = out_row_reg + RW'(ry);
        // narrow rows can wrap the column offset more than once
        for (int i = 0; i < RMAX; i++)
        begin
            if (tcol >= (CW+1)'(w))
            begin
                tcol = tcol - (CW+1)'(w);
                trow = trow + RW'(1);
            end
        end
        // position just consumed is the one before in_*
        due = (in_row_reg > trow) ||
              ((in_row_reg == trow) && ((CW+1)'(in_col_reg) > tcol)) ||
              ((in_row_reg == trow + RW'(1)) && (in_col_reg == '0) &&
               (tcol == (CW+1)'(w) - (CW+1)'(1)));
    end

    // Take: write store and advance input position
    logic skip_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0; in_col_reg <= '0; wp_reg <= '0; skip_reg <= 1'b0;
        end
        else if (cfg_wr || cmd.restart || (cmd.emit && last_next))
        begin
            in_row_reg <= '0; in_col_reg <= '0; wp_reg <= '0;
        end
        else if (cmd.take)
        begin
            skip_reg <= in_frame && drain;
            if (!(in_frame && drain))
            begin
                if (in_col_reg + CW'(1) >= w)
                begin
                    in_col_reg <= '0; in_row_reg <= in_row_reg + RW'(1);
                end
                else
                    in_col_reg <= in_col_reg + CW'(1);
                wp_reg <= (32'(wp_reg) == DEPTH - 1) ? '0 : wp_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && in_frame && !drain)
            store[wp_reg] <= pixel;
    end

    // Window sweep: tap offsets and addresses
    logic [KW-1:0] ty_reg, tx_reg;
    logic [AW-1:0] rowa_reg;       // address of tap row start (at dx=-rx)
    logic          tin;            // tap inside image
    logic signed [RW+1:0] yy;
    logic signed [CW+1:0] xx;
    logic [AW:0] a_s;
    logic [AW-1:0] taddr;
    always_comb
    begin
        yy = $signed({2'b0, out_row_reg}) + $signed((RW+2)'(ty_reg)) - $signed((RW+2)'(ry));
        xx = $signed({2'b0, out_col_reg}) + $signed((CW+2)'(tx_reg)) - $signed((CW+2)'(rx));
        tin = (yy >= 0) && (xx >= 0) && (yy < $signed((RW+2)'(h))) &&
              (xx < $signed((CW+2)'(w)));
        a_s = {1'b0, rowa_reg} + (AW+1)'(tx_reg);
        taddr = (32'(a_s) >= DEPTH) ? AW'(a_s - (AW+1)'(DEPTH)) : a_s[AW-1:0];
    end

    // Row start for the window: obase - ry*W - rx, mod DEPTH (computed stepwise)
    logic [AW:0] sub_s;
    logic [AW:0] add_s;
    logic [AW:0] up_s;
    always_comb
    begin
        sub_s = {1'b0, obase_reg} + (AW+1)'(DEPTH) - (AW+1)'(rx);
        if (32'(sub_s) >= DEPTH) sub_s = sub_s - (AW+1)'(DEPTH);
        add_s = {1'b0, rowa_reg} + (AW+1)'(w);
        if (32'(add_s) >= DEPTH) add_s = add_s - (AW+1)'(DEPTH);
        up_s = {1'b0, rowa_reg} + (AW+1)'(DEPTH) - (AW+1)'(w);
        if (32'(up_s) >= DEPTH) up_s = up_s - (AW+1)'(DEPTH);
    end

    // Counting median: binary search on value, one pass over window per bit
    logic [PIX_W-1:0] rd_reg, lo_reg, cand_reg;
    logic             rv_reg;
    logic             tap_reg;     // last read was a window tap, not a row step
    logic [5:0]       cnt_reg;
    logic [3:0]       bit_reg;
    logic [KW-1:0]    ry_back;
    logic [5:0]       mid;
    logic             win_last;
    assign mid = 6'(({3'b0, kw} * {3'b0, kh} - 6'd1) >> 1);
    assign win_last = (ty_reg == kh - KW'(1)) && (tx_reg == kw - KW'(1));
    assign ry_back = ry;

    // Start row address: obase - ry*W - rx; reached by subtracting W per row offset
    logic [AW-1:0] start_reg;
    logic [KW-1:0] sw_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            rowa_reg <= sub_s[AW-1:0];
            sw_reg <= '0;
            ty_reg <= '0; tx_reg <= '0;
            cnt_reg <= '0;
            bit_reg <= 4'(PIX_W - 1);
            lo_reg <= '0;
            cand_reg <= 8'h80;
        end
        else if (cmd.rd)
        begin
            if (sw_reg < ry_back)
            begin
                // step back one row per read before the sweep starts
                rowa_reg <= up_s[AW-1:0];
                sw_reg <= sw_reg + KW'(1);
                start_reg <= up_s[AW-1:0];
                rv_reg <= 1'b0;
                tap_reg <= 1'b0;
            end
            else
            begin
                rd_reg <= store[taddr];
                rv_reg <= tin;
                tap_reg <= 1'b1;
                if (tx_reg == kw - KW'(1))
                begin
                    tx_reg <= '0;
                    if (ty_reg == kh - KW'(1))
                    begin
                        ty_reg <= '0;
                        rowa_reg <= (ry_back == '0) ? sub_s[AW-1:0] : start_reg;
                    end
                    else
                    begin
                        ty_reg <= ty_reg + KW'(1);
                        rowa_reg <= add_s[AW-1:0];
                    end
                end
                else
                    tx_reg <= tx_reg + KW'(1);
            end
        end
        else if (cmd.acc)
        begin
            // zero padding counts as value 0
            if (tap_reg && ((rv_reg ? rd_reg : 8'd0) < cand_reg))
                cnt_reg <= cnt_reg + 6'd1;
        end
        else if (cmd.pick)
        begin
            // count of values below cand: if > mid, median < cand
            if (cnt_reg <= mid) lo_reg <= cand_reg;
            if (bit_reg != 4'd0)
                cand_reg <= ((cnt_reg <= mid) ? cand_reg : lo_reg) |
                            (8'd1 << (bit_reg - 4'd1));
            bit_reg <= bit_reg - 4'd1;
            cnt_reg <= '0;
        end
    end

    // Sweep completes when last tap was read (after row prewalk)
    logic acc_last_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.rd) acc_last_reg <= (sw_reg >= ry_back) && win_last;
        else if (cmd.check) acc_last_reg <= 1'b0;
    end

    // Output position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_row_reg <= '0; out_col_reg <= '0; obase_reg <= '0;
        end
        else if (cfg_wr || cmd.restart || (cmd.emit && last_next))
        begin
            out_row_reg <= '0; out_col_reg <= '0; obase_reg <= '0;
        end
        else if (cmd.emit)
        begin
            if (out_col_reg + CW'(1) >= w)
            begin
                out_col_reg <= '0; out_row_reg <= out_row_reg + RW'(1);
            end
            else
                out_col_reg <= out_col_reg + CW'(1);
            obase_reg <= (32'(obase_reg) == DEPTH - 1) ? '0 : obase_reg + AW'(1);
        end
    end

    assign sts.skip = skip_reg;
    assign sts.due = due;
    assign sts.win_done = acc_last_reg;
    assign sts.srch_done = (bit_reg == 4'd0);
    // largest candidate whose below-count stayed within mid
    assign med = lo_reg;
    assign last = last_next;
endmodule

### rtl/median_filter_2d_core.sv
// Top level of the 2D median filter with zero padding
//   channel | dir | payload
//   in_s    | in  | {drain, pixel}
//   out_m   | out | {last_of_frame, median}
//   apb     | in  | image size and kernel size registers
// A word for which an output is due is held longer than one for which none is:
// the counting median search walks the window once per result bit through the
// single line store read port, and no new word is taken until it is done.
// Reset clears the input and output position counters; the line store is not cleared.
// A full output register stalls the block until it is taken.
module median_filter_2d_core
    import mf2d_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = MAX_KERNEL_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    mf2d_if.sink              in_s,
    mf2d_if.source            out_m,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic [10:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [2:0]  kernel_width_reg, kernel_height_reg;
    logic        cfg_wr;
    logic [1:0]  ridx;

    assign pready = 1'b1;
    assign ridx = paddr[3:2];
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= 11'd1024; image_height_reg <= 16'd768;
            kernel_width_reg <= 3'd3; kernel_height_reg <= 3'd3;
        end
        else if (cfg_wr)
        begin
            case (ridx)
                REG_WIDTH:  image_width_reg <= pwdata[10:0];
                REG_HEIGHT: image_height_reg <= pwdata[15:0];
                REG_KW:     kernel_width_reg <= pwdata[2:0];
                REG_KH:     kernel_height_reg <= pwdata[2:0];
                default:    image_width_reg <= image_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_WIDTH:  prdata = {21'd0, image_width_reg};
            REG_HEIGHT: prdata = {16'd0, image_height_reg};
            REG_KW:     prdata = {29'd0, kernel_width_reg};
            REG_KH:     prdata = {29'd0, kernel_height_reg};
            default:    prdata = '0;
        endcase
    end

    mf2d_cmd_t cmd;
    mf2d_sts_t sts;
    logic [PIX_W-1:0] med;
    logic last;
    logic out_valid_reg;
    logic [PIX_W:0] out_data_reg;
    logic out_busy;
    logic in_ready;

    assign out_busy = out_valid_reg && !out_m.ready;
    assign in_s.ready = in_ready;

    mf2d_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_s.valid), .in_ready(in_ready),
        .out_busy(out_busy), .sts(sts), .cmd(cmd)
    );

    mf2d_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .pixel(in_s.data[PIX_W-1:0]), .drain(in_s.data[PIX_W]),
        .image_width(image_width_reg), .image_height(image_height_reg),
        .kernel_width(kernel_width_reg), .kernel_height(kernel_height_reg),
        .cfg_wr(cfg_wr), .cmd(cmd), .sts(sts), .med(med), .last(last)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_m.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_data_reg <= {last, med};
    end

    assign out_m.valid = out_valid_reg;
    assign out_m.data = out_data_reg;

`include "assert_macros.svh"
    `ASSERT_CLK(a_emit_free, clk, rst_n, !(cmd.emit && out_busy), "emit into busy output")
    `ASSERT_CLK(a_take_idle, clk, rst_n, !(cmd.take && cmd.emit), "take during emit")
    `ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_m.valid, "emit lost")
endmodule
